// ===== src/mlpd_pkg.sv =====
// Shared types and constants for the magic/type/length packet deframer.
// No dependencies; imported by mlpd_skid, magic_length_packet_deframer, the checker and the testbench.
`default_nettype none

package mlpd_pkg;

  // width kept for the payload length counter (8 to 32)
  localparam int unsigned LENGTH_WIDTH = 32;

  // header layout: four magic bytes, one type byte, four length bytes
  localparam logic [3:0] MagicBytes = 4'd4;
  localparam logic [3:0] TypeIndex  = 4'd4;
  localparam logic [3:0] HeaderLast = 4'd8;

  // configuration register indexes
  localparam int unsigned CfgIdxWidth = 8;
  localparam logic [CfgIdxWidth-1:0] CfgIdxMagic = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CfgIdxType  = 8'd1;

  // event kinds on the result stream
  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_BAD_MAGIC = 2'd2,
    KIND_UNKNOWN   = 2'd3
  } mlpd_kind_e;

  // one result item
  typedef struct packed {
    mlpd_kind_e  kind;
    logic [7:0]  data;
    logic        last;
  } mlpd_result_t;

endpackage

`default_nettype wire

// ===== src/mlpd_skid.sv =====
// Output register with one skid entry for the deframer result stream.
// Depends on mlpd_pkg for the result struct.
`default_nettype none

module mlpd_skid
  import mlpd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire mlpd_result_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output mlpd_result_t      out_data_o
);

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  mlpd_result_t out_q, out_d;
  mlpd_result_t skid_q, skid_d;
  logic         push, pop;

  // ready comes straight from a register: free while the skid entry is empty
  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next-state of the two entries
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_d       = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload flops
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // the skid entry is only ever filled behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("stalled transaction not parked in skid entry");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry did not move to output register");

endmodule

`default_nettype wire

// ===== src/magic_length_packet_deframer.sv =====
// Each result is registered in mlpd_skid before it appears on the master stream.
// One byte per cycle while the skid entry is free; the header parse and payload counter are single-pass
// logic and a two-entry output buffer lets a byte be taken while one result is held.
// Reset (rst_ni low, asynchronous): header gathering restarts, both config
// registers read zero and the output stream is empty.
// Top level of the deframer; depends on mlpd_pkg and mlpd_skid.
`default_nettype none

module magic_length_packet_deframer
  import mlpd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // received byte stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [7:0] payload_byte
  output logic [1:0]                  m_axis_tuser,   // [1:0] event_kind
  output logic                        m_axis_tlast,   // last_of_packet
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [31:0]            cfg_data_i
);

  logic [31:0]             magic_word_q;
  logic [7:0]              data_type_q;
  logic                    in_payload_q, in_payload_d;
  logic [3:0]              header_count_q, header_count_d;
  logic [31:0]             magic_shift_q, magic_shift_d;
  logic [7:0]              current_type_q, current_type_d;
  logic [LENGTH_WIDTH-1:0] remaining_q, remaining_d;
  logic [LENGTH_WIDTH-1:0] remaining_dec;
  logic [LENGTH_WIDTH+7:0] remaining_shift;
  logic                    accept;
  logic                    res_valid;
  mlpd_result_t            res;
  logic                    skid_ready;
  mlpd_result_t            out_data;
  logic                    is_data;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q <= '0;
      data_type_q  <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxMagic) begin
        magic_word_q <= cfg_data_i;
      end else if (cfg_index_i == CfgIdxType) begin
        data_type_q <= cfg_data_i[7:0];
      end
    end
  end

  assign s_axis_tready = skid_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign remaining_dec   = remaining_q - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
  assign remaining_shift = {remaining_q, s_axis_tdata};
  assign is_data         = (current_type_q == data_type_q);

  // header parse and payload count for one byte
  always_comb begin
    in_payload_d   = in_payload_q;
    header_count_d = header_count_q;
    magic_shift_d  = magic_shift_q;
    current_type_d = current_type_q;
    remaining_d    = remaining_q;
    res_valid      = 1'b0;
    res.kind       = KIND_PAYLOAD;
    res.data       = 8'h00;
    res.last       = 1'b0;
    if (in_payload_q) begin
      remaining_d = remaining_dec;
      if (remaining_dec == '0) begin
        in_payload_d   = 1'b0;
        header_count_d = '0;
      end
      if (is_data) begin
        res_valid = 1'b1;
        res.data  = s_axis_tdata;
        res.last  = (remaining_dec == '0);
      end else if (remaining_dec == '0) begin
        res_valid = 1'b1;
        res.kind  = KIND_UNKNOWN;
      end
    end else begin
      if (header_count_q < MagicBytes) begin
        magic_shift_d = {magic_shift_q[23:0], s_axis_tdata};
      end else if (header_count_q == TypeIndex) begin
        current_type_d = s_axis_tdata;
      end else begin
        remaining_d = remaining_shift[LENGTH_WIDTH-1:0];
      end
      header_count_d = header_count_q + 4'd1;
      if (header_count_q == HeaderLast) begin
        header_count_d = '0;
        res_valid      = 1'b1;
        if (magic_shift_q != magic_word_q) begin
          remaining_d = '0;
          res.kind    = KIND_BAD_MAGIC;
        end else if (remaining_d == '0) begin
          res.kind = is_data ? KIND_EMPTY : KIND_UNKNOWN;
        end else begin
          res_valid    = 1'b0;
          in_payload_d = 1'b1;
        end
      end
    end
  end

  // parse state advances on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      header_count_q <= '0;
      magic_shift_q  <= '0;
      current_type_q <= '0;
      remaining_q    <= '0;
    end else if (accept) begin
      in_payload_q   <= in_payload_d;
      header_count_q <= header_count_d;
      magic_shift_q  <= magic_shift_d;
      current_type_q <= current_type_d;
      remaining_q    <= remaining_d;
    end
  end

  // result register with skid entry
  mlpd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept && res_valid),
    .in_ready_o  (skid_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = out_data.data;
  assign m_axis_tuser = out_data.kind;
  assign m_axis_tlast = out_data.last;

  // payload counting always has bytes left to take
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (remaining_q != '0))
    else $error("in payload with zero bytes remaining");

  a_header_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_payload_q |-> (header_count_q <= HeaderLast))
    else $error("header count past last header byte");

  a_event_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != KIND_PAYLOAD)) |->
      (m_axis_tdata == 8'h00 && !m_axis_tlast))
    else $error("non-payload event carries data or last mark");

  a_last_ends_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_payload_q && res_valid && res.last) |=> !in_payload_q)
    else $error("last payload byte did not end payload phase");

endmodule

`default_nettype wire

// ===== verif/mlpd_event_checker.sv =====
// Checker for the packet deframer: watches the byte, result and config channels,
// predicts the event stream and compares it field by field.
// Depends on mlpd_pkg for the result struct, event kinds and register indexes.

module mlpd_event_checker
  import mlpd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // received byte stream
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [7:0]             s_tdata_i,    // [7:0] rx_byte
  // result stream
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [7:0]             m_tdata_i,    // [7:0] payload_byte
  input  logic [1:0]             m_tuser_i,    // [1:0] event_kind
  input  logic                   m_tlast_i,    // last_of_packet
  // configuration writes
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  // status for the testbench top
  output int                     mismatches_o,
  output int                     pending_o
);

  // own copy of the registers and the parser state
  logic [31:0]             magic_reg;
  logic [7:0]              data_type_reg;
  logic                    in_payload;
  logic [3:0]              hdr_count;
  logic [31:0]             magic_acc;
  logic [7:0]              pkt_type;
  logic [LENGTH_WIDTH-1:0] bytes_left;

  mlpd_result_t events_due[$];
  mlpd_result_t due_ev;
  int           err_total;

  // advance the parser by one byte and queue the event it causes, if any
  task automatic deframe_byte(input logic [7:0] rx);
    mlpd_result_t ev;
    logic         is_data;
    ev.kind = KIND_PAYLOAD;
    ev.data = 8'h00;
    ev.last = 1'b0;
    if (in_payload) begin
      bytes_left = bytes_left - 1'b1;
      is_data = (pkt_type == data_type_reg);
      if (bytes_left == '0) begin
        in_payload = 1'b0;
        hdr_count = 4'd0;
      end
      if (is_data) begin
        ev.data = rx;
        ev.last = (bytes_left == '0);
        events_due.push_back(ev);
      end else if (bytes_left == '0) begin
        ev.kind = KIND_UNKNOWN;
        events_due.push_back(ev);
      end
    end else begin
      // big-endian header: magic, type, length
      if (hdr_count < MagicBytes) begin
        magic_acc = {magic_acc[23:0], rx};
      end else if (hdr_count == TypeIndex) begin
        pkt_type = rx;
      end else begin
        bytes_left = (bytes_left << 8) | rx;
      end
      if (hdr_count == HeaderLast) begin
        hdr_count = 4'd0;
        if (magic_acc != magic_reg) begin
          bytes_left = '0;
          ev.kind = KIND_BAD_MAGIC;
          events_due.push_back(ev);
        end else if (bytes_left == '0) begin
          ev.kind = (pkt_type == data_type_reg) ? KIND_EMPTY : KIND_UNKNOWN;
          events_due.push_back(ev);
        end else begin
          in_payload = 1'b1;
        end
      end else begin
        hdr_count = hdr_count + 4'd1;
      end
    end
  endtask

  // sample all channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_reg = '0;
      data_type_reg = '0;
      in_payload = 1'b0;
      hdr_count = 4'd0;
      magic_acc = '0;
      pkt_type = '0;
      bytes_left = '0;
      events_due.delete();
      err_total = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      // register write transaction, unused indexes ignored
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgIdxMagic) begin
          magic_reg = cfg_data_i;
        end else if (cfg_index_i == CfgIdxType) begin
          data_type_reg = cfg_data_i[7:0];
        end
      end
      // result transaction against the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        if (events_due.size() == 0) begin
          $error("result with nothing expected: event_kind %0d payload_byte 0x%02h last %0b",
                 m_tuser_i, m_tdata_i, m_tlast_i);
          err_total++;
        end else begin
          due_ev = events_due.pop_front();
          if (m_tuser_i !== due_ev.kind) begin
            $error("event_kind: expected %0d, actual %0d", due_ev.kind, m_tuser_i);
            err_total++;
          end
          if (m_tdata_i !== due_ev.data) begin
            $error("payload_byte: expected 0x%02h, actual 0x%02h", due_ev.data, m_tdata_i);
            err_total++;
          end
          if (m_tlast_i !== due_ev.last) begin
            $error("last_of_packet: expected %0b, actual %0b", due_ev.last, m_tlast_i);
            err_total++;
          end
        end
      end
      // byte transaction
      if (s_tvalid_i && s_tready_i) begin
        deframe_byte(s_tdata_i);
      end
      mismatches_o <= err_total;
      pending_o <= events_due.size();
    end
  end

endmodule

// ===== verif/tb_magic_length_packet_deframer.sv =====
// Testbench top for the packet deframer: clock, reset, byte and register stimulus,
// receiver back-pressure and the verdict. Depends on mlpd_pkg, the deframer
// and mlpd_event_checker.

module tb_magic_length_packet_deframer;
  import mlpd_pkg::*;

  localparam int HoldCycles = 200;   // long receiver hold-off
  localparam int QuietLimit = 2000;  // cycles with no transaction before giving up
  localparam int DrainGap   = 3;     // cycles after the last result before a write
  localparam int TailCycles = 8;

  // register indexes beyond the two real ones
  localparam logic [CfgIdxWidth-1:0] CfgIdxUnused = 8'd2;
  localparam logic [CfgIdxWidth-1:0] CfgIdxTop    = 8'hFF;

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [7:0]             s_tdata = 8'h00;
  logic                   m_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  logic                   s_tready;
  logic                   m_tvalid;
  logic [7:0]             m_tdata;
  logic [1:0]             m_tuser;
  logic                   m_tlast;
  logic                   cfg_ready;

  int mismatches;
  int pending;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  logic [31:0] magic_now = '0;
  logic [7:0]  type_now = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  magic_length_packet_deframer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  mlpd_event_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one byte, with random idle cycles ahead of it
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk_i); while (!s_tready);
    bytes_sent++;
  endtask

  // stop sending and wait until every expected result has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [31:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgIdxMagic) begin
      magic_now = value;
    end else if (idx == CfgIdxType) begin
      type_now = value[7:0];
    end
  endtask

  // nine header bytes, all fields big-endian
  task automatic push_header(input logic [31:0] magic, input logic [7:0] kind,
                             input logic [31:0] len);
    for (int i = 3; i >= 0; i--) push_byte(magic[8*i +: 8]);
    push_byte(kind);
    for (int i = 3; i >= 0; i--) push_byte(len[8*i +: 8]);
  endtask

  // a whole packet; with retype the data type is switched partway through the payload
  task automatic push_packet(input logic [7:0] kind, input int unsigned len, input bit retype);
    int unsigned split;
    split = retype ? $urandom_range(1, len - 1) : len;
    push_header(magic_now, kind, len);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == split) begin
        write_reg(CfgIdxType, {24'h0, (type_now == kind) ? (kind ^ 8'h01) : kind});
      end
      push_byte(8'($urandom_range(255)));
    end
  endtask

  // one random phase with the given idle rates
  task automatic run_phase(input int s_pct, input int r_pct, input int unsigned n_bytes,
                           input bit with_hold);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  kind;
    bit          held;
    wait_drained();
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    write_reg(CfgIdxMagic, $urandom());
    write_reg(CfgIdxType, $urandom_range(255));
    start = bytes_sent;
    held = 1'b0;
    while (bytes_sent - start < n_bytes) begin
      if (with_hold && !held && (bytes_sent - start > n_bytes / 2)) begin
        hold_req <= hold_req + 1;
        held = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
        // broken header: magic off by one bit, random type and length
        push_header(magic_now ^ (32'h1 << $urandom_range(31)), 8'($urandom_range(255)),
                    $urandom());
      end else begin
        kind = (pick < 70) ? type_now : 8'($urandom_range(255));
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        push_packet(kind, len, (len >= 2) && ($urandom_range(9) == 0));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // all-zero header under reset registers: empty data packet
    push_header(32'h0000_0000, 8'h00, 32'h0000_0000);
    // extreme register values, and writes to indexes that do not exist
    write_reg(CfgIdxMagic, 32'hFFFF_FFFF);
    write_reg(CfgIdxType, 32'h0000_00FF);
    write_reg(CfgIdxUnused, 32'h1234_5678);
    write_reg(CfgIdxTop, 32'hFFFF_FFFF);
    // one-byte data packet, all ones
    push_header(32'hFFFF_FFFF, 8'hFF, 32'h0000_0001);
    push_byte(8'hFF);
    // wrong magic with the largest length: reported as a bad-magic event
    push_header(32'h0000_0000, 8'h7E, 32'hFFFF_FFFF);

    run_phase(14, 53, 270, 1'b0);
    run_phase(53, 14, 270, 1'b0);
    run_phase(0, 0, 270, 1'b1);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
